// ----- design/ggs_pkg.sv -----
package ggs_pkg;

  localparam int ATAN_STAGES_DEF = 14;
  localparam int ATAN_TABLE_LEN  = 20;

  localparam int POS_W  = 15;  // Q4.11 positions, unsigned
  localparam int DIFF_W = 16;  // goal minus pose, signed
  localparam int HEAD_W = 16;  // Q3.13 heading, signed
  localparam int SPD_W  = 15;  // Q4.11 speeds, unsigned
  localparam int TURN_W = 16;  // signed turn command
  localparam int SQ_W   = 30;  // one squared difference
  localparam int DIST_W = 31;  // sum of two squares
  localparam int VEC_W  = 27;  // CORDIC x / y, signed
  localparam int ANG_W  = 28;  // CORDIC angle, Q.24 signed
  localparam int BRG_W  = 17;  // bearing, Q4.13 signed
  localparam int ERR_W  = 18;  // heading error, Q5.13 signed
  localparam int PRESCALE_SH = 8;
  localparam int ROUND_SH    = 11;

  localparam int CFG_IDX_W = 3;

  localparam logic signed [ANG_W-1:0] PI_Q24     = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] ROUND_Q24  = 28'sd1024;
  localparam logic signed [ERR_W-1:0] PI_Q13     = 18'sd25736;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 18'sd51472;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X        = 3'd0,
    REG_GOAL_Y        = 3'd1,
    REG_DRIVE_SPEED   = 3'd2,
    REG_TURN_SPEED    = 3'd3,
    REG_ARRIVE_RADIUS = 3'd4,
    REG_HEADING_TOL   = 3'd5
  } ggs_reg_e;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } ggs_vec_t;

  typedef struct packed {
    logic                     arrived;
    logic                     zero;     // dx == dy == 0, bearing forced to 0
    logic signed [HEAD_W-1:0] heading;
  } ggs_side_t;

  // atan(2^-i) in Q.24
  function automatic logic signed [ANG_W-1:0] atan_q24(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/ggs_front.sv -----
module ggs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ggs_pkg::POS_W-1:0]   pose_x_i,
  input  logic [ggs_pkg::POS_W-1:0]   pose_y_i,
  input  logic signed [ggs_pkg::HEAD_W-1:0] pose_heading_i,
  input  logic [ggs_pkg::POS_W-1:0]   goal_x_i,
  input  logic [ggs_pkg::POS_W-1:0]   goal_y_i,
  input  logic [ggs_pkg::POS_W-1:0]   arrive_radius_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ggs_pkg::ggs_vec_t           out_vec_o,
  output ggs_pkg::ggs_side_t          out_side_o
);
  import ggs_pkg::*;

  // stage A: differences
  logic                      a_vld_q;
  logic signed [DIFF_W-1:0]  a_dx_q, a_dy_q;
  logic signed [HEAD_W-1:0]  a_head_q;
  // stage B: squares and starting vector
  logic                      b_vld_q;
  logic [SQ_W-1:0]           b_sqx_q, b_sqy_q;
  ggs_vec_t                  b_vec_q;
  ggs_side_t                 b_side_q;
  // stage C: arrival compare
  logic                      c_vld_q;
  ggs_vec_t                  c_vec_q;
  ggs_side_t                 c_side_q;

  logic [SQ_W-1:0]           rad2_q;
  logic [2*POS_W-1:0]        rad_prod;

  logic a_rdy, b_rdy, c_rdy;

  logic signed [DIFF_W-1:0]   dx_d, dy_d;
  logic signed [2*DIFF_W-1:0] px, py;
  logic signed [VEC_W-1:0]    xs, ys;
  ggs_vec_t                   init_vec;
  logic [DIST_W-1:0]          dist2;

  assign c_rdy = !c_vld_q || out_ready_i;
  assign b_rdy = !b_vld_q || c_rdy;
  assign a_rdy = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  assign dx_d = $signed({1'b0, goal_x_i}) - $signed({1'b0, pose_x_i});
  assign dy_d = $signed({1'b0, goal_y_i}) - $signed({1'b0, pose_y_i});

  assign px = (2*DIFF_W)'(a_dx_q) * (2*DIFF_W)'(a_dx_q);
  assign py = (2*DIFF_W)'(a_dy_q) * (2*DIFF_W)'(a_dy_q);

  assign xs = {{(VEC_W-DIFF_W-PRESCALE_SH){a_dx_q[DIFF_W-1]}}, a_dx_q, {PRESCALE_SH{1'b0}}};
  assign ys = {{(VEC_W-DIFF_W-PRESCALE_SH){a_dy_q[DIFF_W-1]}}, a_dy_q, {PRESCALE_SH{1'b0}}};

  // left half plane: rotate by pi first so the iterations only cover +-pi/2
  always_comb begin
    if (a_dx_q < 0) begin
      init_vec.x = -xs;
      init_vec.y = -ys;
      init_vec.z = (a_dy_q >= 0) ? PI_Q24 : -PI_Q24;
    end else begin
      init_vec.x = xs;
      init_vec.y = ys;
      init_vec.z = '0;
    end
  end

  assign dist2    = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
  assign rad_prod = (2*POS_W)'(arrive_radius_i) * (2*POS_W)'(arrive_radius_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad2_q <= rad_prod;
    if (a_rdy && in_valid_i) begin
      a_dx_q   <= dx_d;
      a_dy_q   <= dy_d;
      a_head_q <= pose_heading_i;
    end
    if (b_rdy && a_vld_q) begin
      b_sqx_q               <= px[SQ_W-1:0];
      b_sqy_q               <= py[SQ_W-1:0];
      b_vec_q               <= init_vec;
      b_side_q.arrived      <= 1'b0;
      b_side_q.zero         <= (a_dx_q == '0) && (a_dy_q == '0);
      b_side_q.heading      <= a_head_q;
    end
    if (c_rdy && b_vld_q) begin
      c_vec_q               <= b_vec_q;
      c_side_q.zero         <= b_side_q.zero;
      c_side_q.heading      <= b_side_q.heading;
      c_side_q.arrived      <= dist2 < {1'b0, rad2_q};
    end
  end

  assign out_valid_o = c_vld_q;
  assign out_vec_o   = c_vec_q;
  assign out_side_o  = c_side_q;

endmodule

// ----- design/ggs_cordic_cell.sv -----
module ggs_cordic_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ggs_pkg::ggs_vec_t  in_vec_i,
  input  ggs_pkg::ggs_side_t in_side_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ggs_pkg::ggs_vec_t  out_vec_o,
  output ggs_pkg::ggs_side_t out_side_o
);
  import ggs_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN_I = atan_q24(STAGE_IDX);

  logic      vld_q;
  ggs_vec_t  vec_q, vec_d;
  ggs_side_t side_q;
  logic      rdy;

  logic signed [VEC_W-1:0] xsh, ysh;

  assign xsh = in_vec_i.x >>> STAGE_IDX;
  assign ysh = in_vec_i.y >>> STAGE_IDX;

  // one vectoring step: rotate toward y = 0
  always_comb begin
    if (in_vec_i.y > 0) begin
      vec_d.x = in_vec_i.x + ysh;
      vec_d.y = in_vec_i.y - xsh;
      vec_d.z = in_vec_i.z + ATAN_I;
    end else begin
      vec_d.x = in_vec_i.x - ysh;
      vec_d.y = in_vec_i.y + xsh;
      vec_d.z = in_vec_i.z - ATAN_I;
    end
  end

  assign rdy        = !vld_q || out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      vec_q  <= vec_d;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_vec_o   = vec_q;
  assign out_side_o  = side_q;

endmodule

// ----- design/ggs_back.sv -----
module ggs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ggs_pkg::ggs_vec_t          in_vec_i,
  input  ggs_pkg::ggs_side_t         in_side_i,
  input  logic [ggs_pkg::SPD_W-1:0]  drive_speed_i,
  input  logic [ggs_pkg::SPD_W-1:0]  turn_speed_i,
  input  logic [ggs_pkg::SPD_W-1:0]  heading_tol_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ggs_pkg::SPD_W-1:0]  forward_cmd_o,
  output logic signed [ggs_pkg::TURN_W-1:0] turn_cmd_o,
  output logic                       arrived_o
);
  import ggs_pkg::*;

  // stage D: rounded bearing and raw error
  logic                     d_vld_q;
  logic signed [ERR_W-1:0]  d_err_q;
  logic                     d_arr_q;
  // stage E: the output register
  logic                     e_vld_q;
  logic [SPD_W-1:0]         e_fwd_q;
  logic signed [TURN_W-1:0] e_turn_q;
  logic                     e_arr_q;

  logic d_rdy, e_rdy;

  logic signed [ANG_W-1:0]  zr;
  logic signed [BRG_W-1:0]  bearing;
  logic signed [ERR_W-1:0]  err_raw, err_w, mag;
  logic                     turning;
  logic [SPD_W-1:0]         fwd_d;
  logic signed [TURN_W-1:0] turn_d;

  assign zr      = in_vec_i.z + ROUND_Q24;
  assign bearing = in_side_i.zero ? '0 : zr[ANG_W-1:ROUND_SH];
  assign err_raw = {bearing[BRG_W-1], bearing}
                 - {{(ERR_W-HEAD_W){in_side_i.heading[HEAD_W-1]}}, in_side_i.heading};

  // single wrap into [-pi, pi]
  always_comb begin
    if (d_err_q > PI_Q13) begin
      err_w = d_err_q - TWO_PI_Q13;
    end else if (d_err_q < -PI_Q13) begin
      err_w = d_err_q + TWO_PI_Q13;
    end else begin
      err_w = d_err_q;
    end
  end

  assign mag     = (err_w < 0) ? -err_w : err_w;
  assign turning = mag > $signed({{(ERR_W-SPD_W){1'b0}}, heading_tol_i});

  always_comb begin
    fwd_d  = '0;
    turn_d = '0;
    if (!d_arr_q) begin
      if (turning) begin
        turn_d = (err_w > 0) ? $signed({1'b0, turn_speed_i}) : -$signed({1'b0, turn_speed_i});
      end else begin
        fwd_d = drive_speed_i;
      end
    end
  end

  assign e_rdy      = !e_vld_q || out_ready_i;
  assign d_rdy      = !d_vld_q || e_rdy;
  assign in_ready_o = d_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      if (d_rdy) d_vld_q <= in_valid_i;
      if (e_rdy) e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && in_valid_i) begin
      d_err_q <= err_raw;
      d_arr_q <= in_side_i.arrived;
    end
    if (e_rdy && d_vld_q) begin
      e_fwd_q  <= fwd_d;
      e_turn_q <= turn_d;
      e_arr_q  <= d_arr_q;
    end
  end

  assign out_valid_o   = e_vld_q;
  assign forward_cmd_o = e_fwd_q;
  assign turn_cmd_o    = e_turn_q;
  assign arrived_o     = e_arr_q;

  a_arrived_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q && e_arr_q |-> (e_fwd_q == '0) && (e_turn_q == '0))
    else $error("arrived word carries nonzero commands");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q |-> (e_fwd_q == '0) || (e_turn_q == '0))
    else $error("drive and turn commands both nonzero");

  a_fwd_is_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q && (e_fwd_q != '0) |-> e_fwd_q == drive_speed_i)
    else $error("forward command differs from drive speed");

endmodule

// ----- design/go_to_goal_steering.sv -----
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: pose_x, pose_y, pose_heading
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: forward_cmd, turn_cmd; tuser: arrived
// cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One pose word per cycle is taken unless the chain is full; the chain has
// three front stages, one per CORDIC cell, two back stages incl. output reg.
// Every stage has its own valid bit, so bubbles collapse and input is taken
// while the output word waits, until the whole chain is full.
// Reset (async, active low) clears valid bits and loads register defaults.
// Configuration is taken every cycle; tready ripples back combinationally from
// m_axis_tready, and up to ATAN_STAGES + 5 words sit in the chain during a stall.
module go_to_goal_steering #(
  parameter int ATAN_STAGES = ggs_pkg::ATAN_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pose word
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [14:0] pose_x, [29:15] pose_y, [45:30] pose_heading
  // command word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] forward_cmd, [30:15] turn_cmd
  output logic        m_axis_tuser,   // [0] arrived
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [ggs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ggs_pkg::POS_W-1:0]     cfg_data_i
);
  import ggs_pkg::*;

  // configuration registers
  logic [POS_W-1:0] goal_x_q, goal_y_q, arrive_radius_q;
  logic [SPD_W-1:0] drive_speed_q, turn_speed_q, heading_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q        <= '0;
      goal_y_q        <= '0;
      drive_speed_q   <= 15'd2048;
      turn_speed_q    <= '0;
      arrive_radius_q <= 15'd205;
      heading_tol_q   <= 15'd819;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GOAL_X:        goal_x_q        <= cfg_data_i;
        REG_GOAL_Y:        goal_y_q        <= cfg_data_i;
        REG_DRIVE_SPEED:   drive_speed_q   <= cfg_data_i;
        REG_TURN_SPEED:    turn_speed_q    <= cfg_data_i;
        REG_ARRIVE_RADIUS: arrive_radius_q <= cfg_data_i;
        REG_HEADING_TOL:   heading_tol_q   <= cfg_data_i;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // chain links: index 0 is the front output, ATAN_STAGES the last cell
  logic      vld [ATAN_STAGES+1];
  logic      rdy [ATAN_STAGES+1];
  ggs_vec_t  vec [ATAN_STAGES+1];
  ggs_side_t side[ATAN_STAGES+1];

  logic signed [TURN_W-1:0] turn_cmd;
  logic [SPD_W-1:0]         fwd_cmd;

  ggs_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .pose_x_i        (s_axis_tdata[14:0]),
    .pose_y_i        (s_axis_tdata[29:15]),
    .pose_heading_i  (s_axis_tdata[45:30]),
    .goal_x_i        (goal_x_q),
    .goal_y_i        (goal_y_q),
    .arrive_radius_i (arrive_radius_q),
    .out_valid_o     (vld[0]),
    .out_ready_i     (rdy[0]),
    .out_vec_o       (vec[0]),
    .out_side_o      (side[0])
  );

  // one CORDIC vectoring iteration per cell
  for (genvar g = 0; g < ATAN_STAGES; g++) begin : g_cell
    ggs_cordic_cell #(.STAGE_IDX(g)) u_cell (
      .clk_i,
      .rst_ni,
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .in_vec_i    (vec[g]),
      .in_side_i   (side[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .out_vec_o   (vec[g+1]),
      .out_side_o  (side[g+1])
    );
  end

  ggs_back u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i    (vld[ATAN_STAGES]),
    .in_ready_o    (rdy[ATAN_STAGES]),
    .in_vec_i      (vec[ATAN_STAGES]),
    .in_side_i     (side[ATAN_STAGES]),
    .drive_speed_i (drive_speed_q),
    .turn_speed_i  (turn_speed_q),
    .heading_tol_i (heading_tol_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .forward_cmd_o (fwd_cmd),
    .turn_cmd_o    (turn_cmd),
    .arrived_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, turn_cmd, fwd_cmd};

endmodule
